FILE: rtl/srtb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the slow-read thread backoff core.
// No dependencies; imported by every module of the block.
package srtb_pkg;

  localparam int MAX_THREADS = 256;
  localparam int THREAD_CAP  = (MAX_THREADS > 511) ? 511 : MAX_THREADS;
  localparam logic [8:0] THREAD_TOP = 9'(THREAD_CAP);

  localparam logic [19:0] NS_PER_MS = 20'd1000000;
  localparam logic [29:0] NS_PER_S  = 30'd1000000000;

  localparam logic [15:0] MIN_LATENCY_RST  = 16'd1000;
  localparam logic [39:0] MAX_BPS_RST      = 40'd1048576;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd1000;
  localparam logic [7:0]  EVENTS_RST       = 8'd2;
  localparam logic        STEAL_DIS_RST    = 1'b0;
  localparam logic [8:0]  INIT_THREADS_RST = 9'd16;

  typedef enum logic [2:0] {
    REG_MIN_LATENCY  = 3'd0,
    REG_MAX_BPS      = 3'd1,
    REG_MIN_INTERVAL = 3'd2,
    REG_EVENTS       = 3'd3,
    REG_STEAL_DIS    = 3'd4,
    REG_INIT_THREADS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] min_latency_ms;
    logic [39:0] max_bytes_per_sec;
    logic [15:0] min_interval_ms;
    logic [7:0]  events_to_backoff;
    logic        stealing_disabled;
  } cfg_t;

  // Per-report result of the state-free checks
  typedef struct packed {
    logic        long_read;
    logic        below_rate;
    logic [47:0] now_ns;
  } chk_t;

  function automatic logic [8:0] clamp_threads(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (r == 9'd0) r = 9'd1;
    if (r > THREAD_TOP) r = THREAD_TOP;
    return r;
  endfunction

endpackage

FILE: rtl/srtb_rate_check.sv
`timescale 1ns / 1ps
// Input register and throughput/latency check pipeline (three stages).
// Depends on srtb_pkg.
module srtb_rate_check
  import srtb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [39:0]  byte_count,
  input  logic [39:0]  read_ns,
  input  logic [47:0]  now_ns,
  output logic         out_valid,
  input  logic         out_ready,
  output chk_t         chk
);

  logic        v0, v1, v2;
  logic        rdy0, rdy1, rdy2;
  logic [39:0] bytes0, ns0;
  logic [47:0] now0, now1, now2;
  logic [69:0] lhs1;
  logic [59:0] plo1, phi1;
  logic        long1, long2, below2;
  logic [35:0] lat_thr;
  logic [79:0] rhs;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign in_ready = rdy0;

  assign lat_thr = 36'(cfg.min_latency_ms) * 36'(NS_PER_MS);
  assign rhs = 80'(plo1) + {phi1, 20'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      bytes0 <= byte_count;
      ns0    <= read_ns;
      now0   <= now_ns;
    end
    // split the 40x40 product into two 40x20 partials
    if (rdy1) begin
      lhs1  <= 70'(bytes0) * 70'(NS_PER_S);
      plo1  <= 60'(cfg.max_bytes_per_sec) * 60'(ns0[19:0]);
      phi1  <= 60'(cfg.max_bytes_per_sec) * 60'(ns0[39:20]);
      long1 <= 40'(lat_thr) <= ns0;
      now1  <= now0;
    end
    if (rdy2) begin
      below2 <= 80'(lhs1) < rhs;
      long2  <= long1;
      now2   <= now1;
    end
  end

  assign out_valid      = v2;
  assign chk.long_read  = long2;
  assign chk.below_rate = below2;
  assign chk.now_ns     = now2;

endmodule

FILE: rtl/srtb_backoff_ctrl.sv
`timescale 1ns / 1ps
// Backoff state (thread limit, event count, last event time) and result register.
// Depends on srtb_pkg.
module srtb_backoff_ctrl
  import srtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        load,
  input  logic [8:0]  load_threads,
  input  logic        in_valid,
  output logic        in_ready,
  input  chk_t        chk,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  allowed_threads,
  output logic        slow_event,
  output logic        lowered
);

  logic [8:0]  thread_limit, thread_limit_next;
  logic [7:0]  event_count, event_count_next;
  logic [47:0] last_event_time;
  logic [47:0] elapsed;
  logic [35:0] int_thr;
  logic [7:0]  count_inc;
  logic        slow, lower, take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign elapsed   = chk.now_ns - last_event_time;
  assign int_thr   = 36'(cfg.min_interval_ms) * 36'(NS_PER_MS);
  assign count_inc = event_count + 8'd1;

  always_comb begin
    slow = (cfg.min_latency_ms != 16'd0) && !cfg.stealing_disabled && chk.long_read &&
           (thread_limit > 9'd1) && chk.below_rate && (elapsed >= 48'(int_thr));
    lower = 1'b0;
    thread_limit_next = thread_limit;
    event_count_next  = event_count;
    if (slow) begin
      event_count_next = count_inc;
      if (count_inc >= cfg.events_to_backoff) begin
        event_count_next  = 8'd0;
        thread_limit_next = thread_limit - 9'd1;
        lower             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thread_limit    <= clamp_threads(INIT_THREADS_RST);
      event_count     <= 8'd0;
      last_event_time <= 48'd0;
      out_valid       <= 1'b0;
    end else begin
      if (load) begin
        thread_limit <= clamp_threads(load_threads);
      end else if (take) begin
        thread_limit <= thread_limit_next;
      end
      if (take) begin
        event_count <= event_count_next;
        if (slow) last_event_time <= chk.now_ns;
      end
      if (in_ready) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      allowed_threads <= thread_limit_next;
      slow_event      <= slow;
      lowered         <= lower;
    end
  end

`ifndef SYNTHESIS
  a_limit_nonzero: assert property (@(posedge clk) disable iff (rst)
    thread_limit != 9'd0)
    else $error("thread limit reached zero");

  a_lower_needs_slow: assert property (@(posedge clk) disable iff (rst)
    out_valid && lowered |-> slow_event)
    else $error("decrement without slow event");

  a_lower_step: assert property (@(posedge clk) disable iff (rst)
    take && lower && !load |=> thread_limit == $past(thread_limit) - 9'd1)
    else $error("thread limit did not drop by one");

  a_event_time: assert property (@(posedge clk) disable iff (rst)
    take && slow |=> last_event_time == $past(chk.now_ns))
    else $error("last event time not captured");

  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    take && !load |=> allowed_threads == thread_limit)
    else $error("result thread count differs from state");
`endif

endmodule

FILE: rtl/slow_read_thread_backoff_core.sv
`timescale 1ns / 1ps
// Top level of the slow-read thread backoff core: configuration registers,
// check pipeline and backoff state. Depends on srtb_pkg, srtb_rate_check, srtb_backoff_ctrl.
//
// Each read report on the slave stream yields one result on the master stream.
// A new report is taken every cycle unless the master stream stalls the
// pipeline; each report passes the input register (which takes it at the
// accepting edge), then the partial products of the throughput test, the exact
// compare, and the state update into the result register. The throughput test
// bytes*1e9 < limit*ns is exact, with the 40x40 product split into two 40x20
// partials. Backoff state updates as each report enters the result register,
// so consecutive reports see each other's effects. Writing initial_threads
// (index 5) loads the thread count, clamped to 1..256; registers must be written
// only while no report is in flight, which the block itself does not enforce.
module slow_read_thread_backoff_core
  import srtb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [39:0]   cfg_wdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // byte_count[39:0], read_ns[79:40], now_ns[127:80]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata    // allowed_threads[8:0], slow_event[9], lowered[10], zero
);

  cfg_t       cfg;
  chk_t       chk;
  logic       chk_valid, chk_ready;
  logic       load;
  logic [8:0] allowed_threads;
  logic       slow_event, lowered;

  assign load = cfg_we && (cfg_index == REG_INIT_THREADS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_latency_ms    <= MIN_LATENCY_RST;
      cfg.max_bytes_per_sec <= MAX_BPS_RST;
      cfg.min_interval_ms   <= MIN_INTERVAL_RST;
      cfg.events_to_backoff <= EVENTS_RST;
      cfg.stealing_disabled <= STEAL_DIS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LATENCY:  cfg.min_latency_ms    <= cfg_wdata[15:0];
        REG_MAX_BPS:      cfg.max_bytes_per_sec <= cfg_wdata;
        REG_MIN_INTERVAL: cfg.min_interval_ms   <= cfg_wdata[15:0];
        REG_EVENTS:       cfg.events_to_backoff <= cfg_wdata[7:0];
        REG_STEAL_DIS:    cfg.stealing_disabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  srtb_rate_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .byte_count (s_tdata[39:0]),
    .read_ns    (s_tdata[79:40]),
    .now_ns     (s_tdata[127:80]),
    .out_valid  (chk_valid),
    .out_ready  (chk_ready),
    .chk        (chk)
  );

  srtb_backoff_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .load            (load),
    .load_threads    (cfg_wdata[8:0]),
    .in_valid        (chk_valid),
    .in_ready        (chk_ready),
    .chk             (chk),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .allowed_threads (allowed_threads),
    .slow_event      (slow_event),
    .lowered         (lowered)
  );

  assign m_tdata = {5'd0, lowered, slow_event, allowed_threads};

endmodule
